[design/polar_to_rect_vector_set_macros.svh]
// Assertion macros for the polar_to_rect_vector_set block.
// Defining ASSERT_OFF turns every macro into nothing.
`ifndef POLAR_TO_RECT_VECTOR_SET_MACROS_SVH
`define POLAR_TO_RECT_VECTOR_SET_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define PVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/pvs_pkg.sv]
// Shared widths, constants, stage payload type and lookup functions
// for the polar-to-rectangular vector block. No dependencies.
package pvs_pkg;

  localparam int DW          = 24;             // Q12.12 port width
  localparam int GW          = 31;             // signed width of the gain constant
  localparam int PW          = DW + GW;        // gain product width
  localparam int GAIN_SHIFT  = 14;
  localparam int XW          = PW - GAIN_SHIFT + 1;  // x/y datapath, Q.28 fraction for polar items
  localparam int ZW          = 26;             // residual angle, Q10.16 degrees
  localparam int AW          = 21;             // reduced angle in [0, 360) Q9.12, unsigned
  localparam int CW          = 4;              // turn-compare count width
  localparam int FOLD_SHIFT  = 4;              // Q9.12 reduced angle to Q10.16 residual
  localparam int RND_SHIFT   = 16;             // Q.28 back to Q.12
  localparam int TABLE_LEN   = 24;
  localparam int STAGES_DEF  = 16;
  localparam int TURN_SPAN   = 5;              // turn thresholds at -5 .. +5

  localparam int DEG90_Q12   = 368640;
  localparam int DEG180_Q12  = 737280;
  localparam int DEG270_Q12  = 1105920;
  localparam int DEG360_Q12  = 1474560;

  localparam int SAT_MAX     = (2 ** (DW - 1)) - 1;
  localparam int SAT_MIN     = -(2 ** (DW - 1));

  localparam logic signed [GW-1:0] GAIN_Q30 = 31'sd652032874;

  localparam logic [1:0] KIND_RECT  = 2'd0;
  localparam logic [1:0] KIND_POLAR = 2'd1;

  typedef struct packed {
    logic                 vld;
    logic                 polar;
    logic                 bad;
    logic                 neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } pvs_stage_t;

  // atan(2^-i) in Q10.16 degrees
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    unique case (idx)
      5'd0:    atan_q16 = ZW'(2949120);
      5'd1:    atan_q16 = ZW'(1740967);
      5'd2:    atan_q16 = ZW'(919879);
      5'd3:    atan_q16 = ZW'(466945);
      5'd4:    atan_q16 = ZW'(234379);
      5'd5:    atan_q16 = ZW'(117304);
      5'd6:    atan_q16 = ZW'(58666);
      5'd7:    atan_q16 = ZW'(29335);
      5'd8:    atan_q16 = ZW'(14668);
      5'd9:    atan_q16 = ZW'(7334);
      5'd10:   atan_q16 = ZW'(3667);
      5'd11:   atan_q16 = ZW'(1833);
      5'd12:   atan_q16 = ZW'(917);
      5'd13:   atan_q16 = ZW'(458);
      5'd14:   atan_q16 = ZW'(229);
      5'd15:   atan_q16 = ZW'(115);
      5'd16:   atan_q16 = ZW'(57);
      5'd17:   atan_q16 = ZW'(29);
      5'd18:   atan_q16 = ZW'(14);
      5'd19:   atan_q16 = ZW'(7);
      5'd20:   atan_q16 = ZW'(4);
      5'd21:   atan_q16 = ZW'(2);
      5'd22:   atan_q16 = ZW'(1);
      default: atan_q16 = '0;
    endcase
  endfunction

  // Whole turns to add back, given how many turn thresholds the angle reaches
  function automatic logic signed [ZW-1:0] turn_offset(input logic [CW-1:0] cnt);
    logic signed [CW:0] q;
    q = (CW + 1)'(TURN_SPAN + 1) - $signed({1'b0, cnt});
    return ZW'(q * DEG360_Q12);
  endfunction

endpackage

[design/polar_to_rect_vector_set.sv]
// Channel  Handshake              Payload
// in_      in_valid / in_ready    in_kind, in_first_value, in_second_value
// out_     out_valid / out_ready  out_x_out, out_y_out, out_mode_out, out_bad_mode
//
// One item per cycle while the output is not stalled; the registers in order are the
// turn compare, angle reduce, quadrant fold, one rotation stage per CORDIC step,
// sign fix and the output register. Reset clears only valid bits.
// The pipeline advances as one while the skid register is empty; a stalled
// output fills the skid register and then holds the pipeline until drained.
// Depends on pvs_pkg, pvs_cordic_stage and polar_to_rect_vector_set_macros.svh.
`include "polar_to_rect_vector_set_macros.svh"

module polar_to_rect_vector_set #(
  parameter int CORDIC_STAGES = pvs_pkg::STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic signed [pvs_pkg::DW-1:0] in_first_value,
  input  logic signed [pvs_pkg::DW-1:0] in_second_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [pvs_pkg::DW-1:0] out_x_out,
  output logic signed [pvs_pkg::DW-1:0] out_y_out,
  output logic                         out_mode_out,
  output logic                         out_bad_mode
);

  localparam int N  = (CORDIC_STAGES > pvs_pkg::TABLE_LEN) ? pvs_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;
  localparam int DW = pvs_pkg::DW;
  localparam int XW = pvs_pkg::XW;
  localparam int ZW = pvs_pkg::ZW;
  localparam int TW = XW - pvs_pkg::RND_SHIFT;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic                 mode;
    logic                 bad;
  } out_t;

  logic en;

  // stage 1: turn compares and gain product
  logic                          s1_vld_r, s1_polar_r, s1_bad_r;
  logic signed [DW-1:0]          s1_a_r, s1_b_r;
  logic [pvs_pkg::CW-1:0]        s1_cnt_r, s1_cnt_nxt;
  logic signed [pvs_pkg::PW-1:0] s1_prod_r, s1_prod_nxt;

  // stage 2: reduced angle and start vector
  logic                          s2_vld_r, s2_polar_r, s2_bad_r;
  logic [pvs_pkg::AW-1:0]        s2_ang_r, s2_ang_nxt;
  logic signed [XW-1:0]          s2_x_r, s2_x_nxt, s2_y_r, s2_y_nxt;
  logic signed [ZW-1:0]          ang_sum;

  // stage 3: quadrant fold
  pvs_pkg::pvs_stage_t           s3_r, s3_nxt;
  logic signed [ZW-1:0]          a0, z12;

  pvs_pkg::pvs_stage_t           chain [0:N];
  pvs_pkg::pvs_stage_t           sn_r, sn_nxt;

  out_t                          pd, out_d_r, skid_d_r;
  logic                          out_valid_r, skid_v_r;

  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    logic signed [TW-1:0] t;
    s = v + XW'(1 << (pvs_pkg::RND_SHIFT - 1));
    t = s[XW-1:pvs_pkg::RND_SHIFT];
    if (t > TW'(pvs_pkg::SAT_MAX)) begin
      return DW'(pvs_pkg::SAT_MAX);
    end else if (t < TW'(pvs_pkg::SAT_MIN)) begin
      return DW'(pvs_pkg::SAT_MIN);
    end
    return t[DW-1:0];
  endfunction

  assign en       = !skid_v_r;
  assign in_ready = en;

  // ---- stage 1
  always_comb begin
    s1_cnt_nxt = '0;
    for (int k = 0; k <= 2 * pvs_pkg::TURN_SPAN; k++) begin
      if (in_second_value >= DW'((k - pvs_pkg::TURN_SPAN) * pvs_pkg::DEG360_Q12)) begin
        s1_cnt_nxt = s1_cnt_nxt + 1'b1;
      end
    end
    s1_prod_nxt = in_first_value * pvs_pkg::GAIN_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r   <= in_valid;
      s1_polar_r <= (in_kind == pvs_pkg::KIND_POLAR);
      s1_bad_r   <= (in_kind != pvs_pkg::KIND_POLAR) && (in_kind != pvs_pkg::KIND_RECT);
      s1_a_r     <= in_first_value;
      s1_b_r     <= in_second_value;
      s1_cnt_r   <= s1_cnt_nxt;
      s1_prod_r  <= s1_prod_nxt;
    end
  end

  // ---- stage 2
  always_comb begin
    ang_sum    = ZW'(s1_b_r) + pvs_pkg::turn_offset(s1_cnt_r);
    s2_ang_nxt = ang_sum[pvs_pkg::AW-1:0];
    if (s1_polar_r) begin
      s2_x_nxt = {s1_prod_r[pvs_pkg::PW-1], s1_prod_r[pvs_pkg::PW-1:pvs_pkg::GAIN_SHIFT]};
      s2_y_nxt = '0;
    end else if (s1_bad_r) begin
      s2_x_nxt = '0;
      s2_y_nxt = '0;
    end else begin
      s2_x_nxt = XW'(s1_a_r);
      s2_y_nxt = XW'(s1_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r   <= s1_vld_r;
      s2_polar_r <= s1_polar_r;
      s2_bad_r   <= s1_bad_r;
      s2_ang_r   <= s2_ang_nxt;
      s2_x_r     <= s2_x_nxt;
      s2_y_r     <= s2_y_nxt;
    end
  end

  // ---- stage 3: fold [0, 360) into [-90, 90], flip sign for the back half
  always_comb begin
    a0            = ZW'(s2_ang_r);
    s3_nxt.vld    = s2_vld_r;
    s3_nxt.polar  = s2_polar_r;
    s3_nxt.bad    = s2_bad_r;
    s3_nxt.x      = s2_x_r;
    s3_nxt.y      = s2_y_r;
    priority if (a0 <= ZW'(pvs_pkg::DEG90_Q12)) begin
      z12        = a0;
      s3_nxt.neg = 1'b0;
    end else if (a0 < ZW'(pvs_pkg::DEG270_Q12)) begin
      z12        = a0 - ZW'(pvs_pkg::DEG180_Q12);
      s3_nxt.neg = 1'b1;
    end else begin
      z12        = a0 - ZW'(pvs_pkg::DEG360_Q12);
      s3_nxt.neg = 1'b0;
    end
    s3_nxt.z = z12 <<< pvs_pkg::FOLD_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  // ---- rotation stages
  assign chain[0] = s3_r;

  for (genvar i = 0; i < N; i++) begin : g_rot
    pvs_cordic_stage #(
      .SHIFT (i)
    ) u_rot (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .st_i  (chain[i]),
      .st_o  (chain[i+1])
    );
  end

  // ---- sign fix
  always_comb begin
    sn_nxt = chain[N];
    if (chain[N].polar && chain[N].neg) begin
      sn_nxt.x = -chain[N].x;
      sn_nxt.y = -chain[N].y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_r.vld <= 1'b0;
    end else if (en) begin
      sn_r <= sn_nxt;
    end
  end

  // ---- round and saturate polar results, output register with skid
  always_comb begin
    pd.mode = sn_r.polar;
    pd.bad  = sn_r.bad;
    if (sn_r.polar) begin
      pd.x = rnd_sat(sn_r.x);
      pd.y = rnd_sat(sn_r.y);
    end else begin
      pd.x = sn_r.x[DW-1:0];
      pd.y = sn_r.y[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (!out_valid_r || out_ready) begin
        // drain skid first, else take the pipeline head
        if (skid_v_r) begin
          out_valid_r <= 1'b1;
          skid_v_r    <= 1'b0;
        end else begin
          out_valid_r <= sn_r.vld;
        end
      end else if (sn_r.vld && en) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_d_r <= skid_v_r ? skid_d_r : pd;
    end
    if (out_valid_r && !out_ready && en) begin
      skid_d_r <= pd;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x_out    = out_d_r.x;
  assign out_y_out    = out_d_r.y;
  assign out_mode_out = out_d_r.mode;
  assign out_bad_mode = out_d_r.bad;

  `PVS_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_v_r, out_valid_r, "skid full with empty output register")
  `PVS_ASSERT_IMP(a_skid_load, clk, rst_n, $rose(skid_v_r), $past(out_valid_r && !out_ready), "skid loaded without output stall")
  `PVS_ASSERT_NXT(a_skid_drain, clk, rst_n, skid_v_r && out_ready, out_valid_r && !skid_v_r, "skid transfer to output lost")
  `PVS_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && out_bad_mode, (out_x_out == '0) && (out_y_out == '0) && !out_mode_out, "bad mode result not zeroed")

endmodule

[design/pvs_cordic_stage.sv]
// One registered rotation step of the CORDIC pipeline.
// Depends on pvs_pkg for the stage payload type and the arctangent table.
module pvs_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  pvs_pkg::pvs_stage_t st_i,
  output pvs_pkg::pvs_stage_t st_o
);

  pvs_pkg::pvs_stage_t st_r;
  pvs_pkg::pvs_stage_t st_nxt;
  logic signed [pvs_pkg::XW-1:0] dx;
  logic signed [pvs_pkg::XW-1:0] dy;
  logic signed [pvs_pkg::ZW-1:0] at;

  always_comb begin
    dx     = $signed(st_i.y) >>> SHIFT;
    dy     = $signed(st_i.x) >>> SHIFT;
    at     = pvs_pkg::atan_q16(5'(SHIFT));
    st_nxt = st_i;
    // pass-through items ride along untouched
    if (st_i.polar) begin
      if (!st_i.z[pvs_pkg::ZW-1]) begin
        st_nxt.x = st_i.x - dx;
        st_nxt.y = st_i.y + dy;
        st_nxt.z = st_i.z - at;
      end else begin
        st_nxt.x = st_i.x + dx;
        st_nxt.y = st_i.y - dy;
        st_nxt.z = st_i.z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule
